@@ hdl/subset_independence_table_macros.svh @@
// ----------------------------------------------------------------------------
// Subset independence table assertion macros
// Shared assertion forms, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SUBSET_INDEPENDENCE_TABLE_MACROS_SVH
`define SUBSET_INDEPENDENCE_TABLE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SIT_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SIT_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/sit_pkg.sv @@
// ----------------------------------------------------------------------------
// Subset independence table package
// Opcodes, fixed field widths and a helper function for the table block.
// ----------------------------------------------------------------------------
package sit_pkg;

	localparam int OP_W   = 2;
	localparam int VIDX_W = 4;
	localparam int VCNT_W = 4;

	typedef logic [OP_W-1:0] opcode_t;

	localparam opcode_t OP_WRITE = 2'd0;
	localparam opcode_t OP_BUILD = 2'd1;
	localparam opcode_t OP_QUERY = 2'd2;
	localparam opcode_t OP_NONE  = 2'd3;

	// Masks whose complement holds no independent set larger than this
	// meet every independent four-set.
	localparam int FOUR_SET_LIMIT = 3;

	function automatic logic [5:0] pop_count(input logic [31:0] x);
		logic [5:0] c;
		c = '0;
		for (int i = 0; i < 32; i++) begin
			c = c + 6'(x[i]);
		end
		return c;
	endfunction

endpackage

@@ hdl/sit_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, two read ports with read enable, registered read data.
// ----------------------------------------------------------------------------
module sit_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

@@ hdl/subset_independence_table.sv @@
// ----------------------------------------------------------------------------
// Subset independence table
// Maximum independent subset sizes over all vertex masks of a small graph.
// ----------------------------------------------------------------------------
// Row writes and queries are taken one per cycle unless stalled; a query
// result passes from both table memory ports through the result stage to the
// output register. A build visits the 2^d masks of the d vertices in use:
// one mask is read, combined and written back per cycle through the single
// write port of the table memory; no input is taken meanwhile. Candidate
// count and least candidate size accumulate while the table is written.
// The table needs no clearing pass; a query before a build answers zeros.
`include "subset_independence_table_macros.svh"

module subset_independence_table #(
	parameter int MAX_VERTICES = 13
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_wr_en,
	input  logic [sit_pkg::VCNT_W-1:0]              cfg_wr_data,
	input  logic                                    in_valid,
	output logic                                    in_stall,
	input  logic [sit_pkg::OP_W-1:0]                opcode,
	input  logic [sit_pkg::VIDX_W-1:0]              vertex_index,
	input  logic [MAX_VERTICES-1:0]                 neighbor_bits,
	input  logic [MAX_VERTICES-1:0]                 query_mask,
	output logic                                    out_valid,
	input  logic                                    out_stall,
	output logic [sit_pkg::OP_W-1:0]                result_kind,
	output logic [$clog2(MAX_VERTICES+2)-1:0]       mask_best_size,
	output logic [$clog2(MAX_VERTICES+2)-1:0]       complement_best_size,
	output logic                                    mask_is_independent,
	output logic                                    hits_every_four_set,
	output logic [$clog2(MAX_VERTICES+2)-1:0]       mask_popcount,
	output logic [MAX_VERTICES:0]                   candidate_count,
	output logic [$clog2(MAX_VERTICES+2)-1:0]       smallest_candidate_size
);

	localparam int AW  = MAX_VERTICES;
	localparam int SW  = $clog2(MAX_VERTICES + 2);
	localparam int DW  = SW + 1;
	localparam int VDW = $clog2(MAX_VERTICES + 1);
	localparam int CW  = MAX_VERTICES + 1;
	localparam int IW  = $clog2(MAX_VERTICES);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_BUILD = 2'd1;
	localparam logic [1:0] ST_FIN   = 2'd2;

	logic [sit_pkg::VCNT_W-1:0] vcount_q;
	logic [AW-1:0]              rows_q [MAX_VERTICES];
	logic                       tvalid_q;
	logic [CW-1:0]              total_q;
	logic [SW-1:0]              least_q;
	logic [1:0]                 state_q;
	logic [AW:0]                iss_q;

	logic                       bld_v_s1;
	logic [AW-1:0]              bld_m_s1;
	logic                       bld_zero_s1;
	logic                       bld_hit_s1;
	logic [SW-1:0]              bld_pc_s1;
	logic                       fwd_a_s1;
	logic                       fwd_b_s1;
	logic [DW-1:0]              fwd_word_q;

	logic                       pend_s1;
	sit_pkg::opcode_t           kind_s1;
	logic                       qok_s1;
	logic [SW-1:0]              pc_s1;

	logic                       out_valid_q;
	sit_pkg::opcode_t           kind_q;
	logic [SW-1:0]              best_m_q;
	logic [SW-1:0]              best_c_q;
	logic                       indep_q;
	logic                       hits_q;
	logic [SW-1:0]              pc_q;
	logic [CW-1:0]              cand_q;
	logic [SW-1:0]              least_out_q;

	logic [VDW-1:0]             d_use;
	logic [AW-1:0]              full_mask;
	logic [4:0]                 vc_ext;

	logic                       s1_adv;
	logic                       accept;
	logic                       res_accept;
	logic                       q_accept;
	logic [AW-1:0]              q_m;
	logic [AW-1:0]              q_c;

	logic                       issuing;
	logic [AW-1:0]              m_iss;
	logic [AW-1:0]              rest_iss;
	logic [AW-1:0]              low_iss;
	logic [AW-1:0]              row_iss;
	logic [AW-1:0]              addr_b_iss;

	logic [DW-1:0]              rd_a;
	logic [DW-1:0]              rd_b;
	logic [DW-1:0]              word_a;
	logic [DW-1:0]              word_b;
	logic [SW-1:0]              best_b1;
	logic [SW-1:0]              new_best;
	logic                       new_ind;
	logic [DW-1:0]              wr_word;
	logic                       cand_hit;

	logic                       re;
	logic [AW-1:0]              raddr_a;
	logic [AW-1:0]              raddr_b;

	// Vertices in use, saturated to 1..MAX_VERTICES.
	always_comb begin
		vc_ext = {1'b0, vcount_q};
		if (vcount_q == '0) begin
			d_use = VDW'(1);
		end else if (vc_ext > 5'(MAX_VERTICES)) begin
			d_use = VDW'(MAX_VERTICES);
		end else begin
			d_use = VDW'(vcount_q);
		end
		for (int i = 0; i < AW; i++) begin
			full_mask[i] = (i < int'(d_use));
		end
	end

	assign s1_adv   = pend_s1 && (!out_valid_q || !out_stall);
	assign in_stall = (state_q != ST_IDLE) || (pend_s1 && !s1_adv);
	assign accept   = in_valid && !in_stall;
	// A build answers only when it finishes; writes and queries answer at once.
	assign res_accept = accept && (opcode inside {sit_pkg::OP_WRITE, sit_pkg::OP_QUERY});
	assign q_accept = accept && (opcode == sit_pkg::OP_QUERY);
	assign q_m      = query_mask & full_mask;
	assign q_c      = full_mask ^ q_m;

	// Build issue: drop the lowest vertex of the mask and its neighbors.
	always_comb begin
		issuing  = (state_q == ST_BUILD) && (iss_q <= {1'b0, full_mask});
		m_iss    = iss_q[AW-1:0];
		rest_iss = m_iss & (m_iss - 1'b1);
		low_iss  = m_iss & (~m_iss + 1'b1);
		row_iss  = '0;
		for (int i = 0; i < AW; i++) begin
			row_iss = row_iss | (rows_q[i] & {AW{low_iss[i]}});
		end
		addr_b_iss = rest_iss & ~row_iss & full_mask;
	end

	// Combine stage: take the entry just written when the read missed it.
	always_comb begin
		word_a  = fwd_a_s1 ? fwd_word_q : rd_a;
		word_b  = fwd_b_s1 ? fwd_word_q : rd_b;
		best_b1 = word_b[SW-1:0] + 1'b1;
		if (bld_zero_s1) begin
			new_best = '0;
			new_ind  = 1'b1;
		end else begin
			new_best = (word_a[SW-1:0] > best_b1) ? word_a[SW-1:0] : best_b1;
			new_ind  = word_a[SW] && !bld_hit_s1;
		end
		wr_word  = {new_ind, new_best};
		cand_hit = ({1'b0, new_best} <= (SW + 1)'(sit_pkg::FOUR_SET_LIMIT));
	end

	assign re      = issuing || q_accept;
	assign raddr_a = issuing ? rest_iss : q_m;
	assign raddr_b = issuing ? addr_b_iss : q_c;

	sit_ram #(
		.WIDTH (DW),
		.DEPTH (1 << AW)
	) u_table (
		.clk     (clk),
		.we      (bld_v_s1),
		.waddr   (bld_m_s1),
		.wdata   (wr_word),
		.re      (re),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (rd_a),
		.rdata_b (rd_b)
	);

	// Control, configuration, rows and build accumulators.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= sit_pkg::VCNT_W'(13);
			for (int i = 0; i < MAX_VERTICES; i++) begin
				rows_q[i] <= '0;
			end
			tvalid_q <= 1'b0;
			total_q  <= '0;
			least_q  <= '0;
			state_q  <= ST_IDLE;
			iss_q    <= '0;
			bld_v_s1 <= 1'b0;
			fwd_a_s1 <= 1'b0;
			fwd_b_s1 <= 1'b0;
			pend_s1  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				vcount_q <= cfg_wr_data;
				tvalid_q <= 1'b0;
			end

			if (accept && (opcode == sit_pkg::OP_WRITE)) begin
				if ({1'b0, vertex_index} < 5'(MAX_VERTICES)) begin
					rows_q[vertex_index[IW-1:0]] <= neighbor_bits;
				end
				tvalid_q <= 1'b0;
			end

			bld_v_s1 <= issuing;
			fwd_a_s1 <= bld_v_s1 && (rest_iss == bld_m_s1);
			fwd_b_s1 <= bld_v_s1 && (addr_b_iss == bld_m_s1);

			if (bld_v_s1 && cand_hit) begin
				total_q <= total_q + 1'b1;
				if (bld_pc_s1 < least_q) begin
					least_q <= bld_pc_s1;
				end
			end

			case (state_q)
				ST_IDLE: begin
					if (accept && (opcode == sit_pkg::OP_BUILD)) begin
						state_q <= ST_BUILD;
						iss_q   <= '0;
						total_q <= '0;
						least_q <= SW'(d_use) + 1'b1;
					end
				end
				ST_BUILD: begin
					if (issuing) begin
						iss_q <= iss_q + 1'b1;
					end else if (!bld_v_s1) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					tvalid_q <= 1'b1;
					state_q  <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			// Hold the result stage until the output register frees up.
			if (res_accept) begin
				pend_s1 <= 1'b1;
			end else if (state_q == ST_FIN) begin
				pend_s1 <= 1'b1;
			end else if (s1_adv) begin
				pend_s1 <= 1'b0;
			end

			if (s1_adv) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Build and result payload.
	always_ff @(posedge clk) begin
		if (issuing) begin
			bld_m_s1    <= m_iss;
			bld_zero_s1 <= (m_iss == '0);
			bld_hit_s1  <= |(row_iss & rest_iss);
			bld_pc_s1   <= SW'(d_use) - SW'(sit_pkg::pop_count(32'(m_iss)));
		end
		fwd_word_q <= wr_word;

		if (res_accept) begin
			kind_s1 <= opcode;
			qok_s1  <= (opcode == sit_pkg::OP_QUERY) && tvalid_q;
			pc_s1   <= SW'(sit_pkg::pop_count(32'(q_m)));
		end else if (state_q == ST_FIN) begin
			kind_s1 <= sit_pkg::OP_BUILD;
			qok_s1  <= 1'b0;
		end

		if (s1_adv) begin
			kind_q      <= kind_s1;
			best_m_q    <= '0;
			best_c_q    <= '0;
			indep_q     <= 1'b0;
			hits_q      <= 1'b0;
			pc_q        <= '0;
			cand_q      <= '0;
			least_out_q <= '0;
			if (qok_s1) begin
				best_m_q    <= rd_a[SW-1:0];
				best_c_q    <= rd_b[SW-1:0];
				indep_q     <= rd_a[SW];
				hits_q      <= ({1'b0, rd_b[SW-1:0]} <=
					(SW + 1)'(sit_pkg::FOUR_SET_LIMIT));
				pc_q        <= pc_s1;
				cand_q      <= total_q;
				least_out_q <= least_q;
			end else if (kind_s1 == sit_pkg::OP_BUILD) begin
				cand_q      <= total_q;
				least_out_q <= least_q;
			end
		end
	end

	assign out_valid               = out_valid_q;
	assign result_kind             = kind_q;
	assign mask_best_size          = best_m_q;
	assign complement_best_size    = best_c_q;
	assign mask_is_independent     = indep_q;
	assign hits_every_four_set     = hits_q;
	assign mask_popcount           = pc_q;
	assign candidate_count         = cand_q;
	assign smallest_candidate_size = least_out_q;

	`SIT_ASSERT_NOW(a_bld_in_build, bld_v_s1, state_q == ST_BUILD, "table write outside build")
	`SIT_ASSERT_NOW(a_s1_empty_build, state_q == ST_BUILD, !pend_s1, "result pending during build")
	`SIT_ASSERT_NOW(a_fwd_after_wr, fwd_a_s1 || fwd_b_s1, $past(bld_v_s1), "forward without write")
	`SIT_ASSERT_NEXT(a_s1_to_out, s1_adv, out_valid_q, "result lost on advance")

endmodule

@@ tb/sv/subset_independence_table_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Subset independence table testbench
// Drives row writes, builds and mask queries through the valid/stall channels
// and checks every result beat against a built-in table predictor or the
// typed answer of its row. A typed table of edge cases runs first, then
// random graph episodes under several vertex counts and idling patterns.
// ----------------------------------------------------------------------------
module subset_independence_table_tb;

	localparam int VERTS = 13;
	localparam int TABLE_SIZE = 1 << VERTS;
	localparam int ITEMS_PER_PHASE = 130;
	localparam int PHASES = 12;
	localparam int QUIET_LIMIT = 40000;
	// vertex count per random phase; phase p idles in pattern p % 4
	localparam logic [PHASES-1:0][3:0] PHASE_COUNTS = {4'd14, 4'd4, 4'd6, 4'd8, 4'd1,
		4'd13, 4'd7, 4'd5, 4'd3, 4'd2, 4'd15, 4'd0};

	typedef struct packed {
		sit_pkg::opcode_t kind;
		logic [3:0]  best;
		logic [3:0]  comp_best;
		logic        indep;
		logic        hits;
		logic [3:0]  pop;
		logic [13:0] cand;
		logic [3:0]  least;
	} answer_t;

	typedef struct packed {
		sit_pkg::opcode_t op;
		logic [3:0]  vidx;
		logic [12:0] nbits;
		logic [12:0] qmask;
		logic        typed;
		answer_t     want;
	} stim_row_t;

	localparam answer_t WRITE_ACK = '{kind: sit_pkg::OP_WRITE, default: '0};
	localparam answer_t EMPTY_QUERY = '{kind: sit_pkg::OP_QUERY, default: '0};
	localparam answer_t BY_MODEL = '0;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [3:0]  cfg_wr_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	sit_pkg::opcode_t opcode = sit_pkg::OP_WRITE;
	logic [3:0]  vertex_index = '0;
	logic [12:0] neighbor_bits = '0;
	logic [12:0] query_mask = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	sit_pkg::opcode_t result_kind;
	logic [3:0]  mask_best_size;
	logic [3:0]  complement_best_size;
	logic        mask_is_independent;
	logic        hits_every_four_set;
	logic [3:0]  mask_popcount;
	logic [13:0] candidate_count;
	logic [3:0]  smallest_candidate_size;

	// predictor state
	logic [3:0]  vcount = 4'd13;
	logic [12:0] adj_rows [0:VERTS-1];
	logic [3:0]  size_tbl [0:TABLE_SIZE-1];
	logic        indep_tbl [0:TABLE_SIZE-1];
	logic        tables_ok = 1'b0;
	logic [13:0] cand_total = '0;
	logic [3:0]  least_cand = '0;

	answer_t     expected_answers [$];
	stim_row_t   directed_rows [0:19];
	int          err_count = 0;
	int          gap_pct = 0;
	int          stall_pct = 0;
	int          quiet_cycles = 0;

	subset_independence_table DUT (
		.clk                     (clk),
		.arst_n                  (arst_n),
		.cfg_wr_en               (cfg_wr_en),
		.cfg_wr_data             (cfg_wr_data),
		.in_valid                (in_valid),
		.in_stall                (in_stall),
		.opcode                  (opcode),
		.vertex_index            (vertex_index),
		.neighbor_bits           (neighbor_bits),
		.query_mask              (query_mask),
		.out_valid               (out_valid),
		.out_stall               (out_stall),
		.result_kind             (result_kind),
		.mask_best_size          (mask_best_size),
		.complement_best_size    (complement_best_size),
		.mask_is_independent     (mask_is_independent),
		.hits_every_four_set     (hits_every_four_set),
		.mask_popcount           (mask_popcount),
		.candidate_count         (candidate_count),
		.smallest_candidate_size (smallest_candidate_size)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int unsigned used_count();
		if (vcount == 4'd0) begin
			return 1;
		end
		if (int'(vcount) > VERTS) begin
			return VERTS;
		end
		return int'(vcount);
	endfunction

	function automatic void build_size_tables();
		int unsigned d, full, total, least, low, rest, row, a, b;
		d = used_count();
		full = (1 << d) - 1;
		total = 0;
		least = d + 1;
		size_tbl[0] = '0;
		indep_tbl[0] = 1'b1;
		for (int unsigned m = 1; m <= full; m++) begin
			low = 0;
			while (((m >> low) & 1) == 0) begin
				low++;
			end
			rest = m & (m - 1);
			row = int'(adj_rows[low]);
			a = int'(size_tbl[rest]);
			b = 1 + int'(size_tbl[rest & ~row & full]);
			size_tbl[m] = 4'((a > b) ? a : b);
			indep_tbl[m] = indep_tbl[rest] && ((row & rest) == 0);
		end
		for (int unsigned m = 0; m <= full; m++) begin
			if (int'(size_tbl[full ^ m]) <= sit_pkg::FOUR_SET_LIMIT) begin
				total++;
				if ($countones(m) < least) begin
					least = $countones(m);
				end
			end
		end
		cand_total = 14'(total);
		least_cand = 4'(least);
		tables_ok = 1'b1;
	endfunction

	// Returns 0 when the item yields no result beat.
	function automatic bit predict_answer(input sit_pkg::opcode_t op, input logic [3:0] vi,
		input logic [12:0] nb, input logic [12:0] qm, output answer_t ans);
		int unsigned full, m, c;
		ans = '0;
		if (op == sit_pkg::OP_NONE) begin
			return 1'b0;
		end
		ans.kind = op;
		if (op == sit_pkg::OP_WRITE) begin
			if (int'(vi) < VERTS) begin
				adj_rows[vi] = nb;
			end
			tables_ok = 1'b0;
		end else if (op == sit_pkg::OP_BUILD) begin
			build_size_tables();
			ans.cand = cand_total;
			ans.least = least_cand;
		end else if (tables_ok) begin
			full = (1 << used_count()) - 1;
			m = int'(qm) & full;
			c = full ^ m;
			ans.best = size_tbl[m];
			ans.comp_best = size_tbl[c];
			ans.indep = indep_tbl[m];
			ans.hits = int'(size_tbl[c]) <= sit_pkg::FOUR_SET_LIMIT;
			ans.pop = 4'($countones(m));
			ans.cand = cand_total;
			ans.least = least_cand;
		end
		return 1'b1;
	endfunction

	function automatic logic [12:0] random_row(input int unsigned dens);
		logic [12:0] r1, r2, r3;
		r1 = 13'($urandom);
		r2 = 13'($urandom);
		r3 = 13'($urandom);
		case (dens)
			0: return r1 & r2;
			1: return r1;
			2: return r1 | r2;
			default: return r1 | r2 | r3;
		endcase
	endfunction

	task automatic report_error(input string msg);
		err_count++;
		$display("ERROR at %0t: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input logic [13:0] got,
		input logic [13:0] want);
		if (got !== want) begin
			report_error($sformatf("%s got %0d expected %0d", name, got, want));
		end
	endtask

	task automatic put_item(input stim_row_t r);
		answer_t predicted;
		bit has;
		while ($urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= r.op;
		vertex_index <= r.vidx;
		neighbor_bits <= r.nbits;
		query_mask <= r.qmask;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		has = predict_answer(r.op, r.vidx, r.nbits, r.qmask, predicted);
		if (has) begin
			expected_answers.push_back(r.typed ? r.want : predicted);
		end
	endtask

	task automatic wait_drained();
		while (expected_answers.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic run_phase(input int p);
		int unsigned stage, left, dens, sent, d;
		stim_row_t r;
		// let any no-result beat clear the pipe before touching the register
		wait_drained();
		repeat (8) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= PHASE_COUNTS[p];
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		vcount = PHASE_COUNTS[p];
		tables_ok = 1'b0;
		case (p % 4)
			0: begin gap_pct = 0; stall_pct = 0; end
			1: begin gap_pct = 46; stall_pct = 0; end
			2: begin gap_pct = 0; stall_pct = 46; end
			default: begin gap_pct = 27; stall_pct = 27; end
		endcase
		d = used_count();
		stage = 2;
		left = 0;
		dens = 0;
		sent = 0;
		while (sent < ITEMS_PER_PHASE) begin
			r = '0;
			r.vidx = 4'($urandom_range(0, 15));
			r.nbits = 13'($urandom);
			r.qmask = 13'($urandom);
			if ($urandom_range(0, 99) < 8) begin
				r.op = sit_pkg::opcode_t'($urandom_range(0, 3));
			end else begin
				// episodes: rows, one build, then a run of queries
				if (left == 0) begin
					stage = (stage + 1) % 3;
					case (stage)
						0: begin
							left = $urandom_range(1, VERTS);
							dens = $urandom_range(0, 3);
						end
						1: left = 1;
						default: left = (d < 10) ? $urandom_range(5, 30) : $urandom_range(60, 120);
					endcase
				end
				left--;
				case (stage)
					0: begin
						r.op = sit_pkg::OP_WRITE;
						r.vidx = 4'($urandom_range(0, VERTS - 1));
						r.nbits = random_row(dens);
					end
					1: r.op = sit_pkg::OP_BUILD;
					default: begin
						r.op = sit_pkg::OP_QUERY;
						if ($urandom_range(0, 15) == 0) begin
							r.qmask = ($urandom_range(0, 1) == 0) ? 13'h0000 : 13'h1FFF;
						end
					end
				endcase
			end
			put_item(r);
			if (r.op != sit_pkg::OP_NONE) begin
				sent++;
			end
		end
		in_valid <= 1'b0;
	endtask

	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	always @(posedge clk) begin
		answer_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_answers.size() == 0) begin
				report_error($sformatf("result beat kind %0d with nothing expected",
					result_kind));
			end else begin
				want = expected_answers.pop_front();
				check_field("result_kind", 14'(result_kind), 14'(want.kind));
				check_field("mask_best_size", 14'(mask_best_size), 14'(want.best));
				check_field("complement_best_size", 14'(complement_best_size),
					14'(want.comp_best));
				check_field("mask_is_independent", 14'(mask_is_independent),
					14'(want.indep));
				check_field("hits_every_four_set", 14'(hits_every_four_set),
					14'(want.hits));
				check_field("mask_popcount", 14'(mask_popcount), 14'(want.pop));
				check_field("candidate_count", candidate_count, want.cand);
				check_field("smallest_candidate_size", 14'(smallest_candidate_size),
					14'(want.least));
			end
		end
	end

	// a full 13-vertex build holds input while it walks all 2^13 masks
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		for (int k = 0; k < VERTS; k++) begin
			adj_rows[k] = '0;
		end
		for (int k = 0; k < TABLE_SIZE; k++) begin
			size_tbl[k] = '0;
			indep_tbl[k] = 1'b0;
		end
		// vertex count stays at its reset value of 13 here
		directed_rows = '{
			'{sit_pkg::OP_QUERY, 4'd0,  13'h0000, 13'h1FFF, 1'b1, EMPTY_QUERY},
			'{sit_pkg::OP_WRITE, 4'd15, 13'h1FFF, 13'h0000, 1'b1, WRITE_ACK},
			'{sit_pkg::OP_WRITE, 4'd13, 13'h1555, 13'h1FFF, 1'b1, WRITE_ACK},
			'{sit_pkg::OP_NONE,  4'd7,  13'h0AAA, 13'h1555, 1'b1, BY_MODEL},
			'{sit_pkg::OP_WRITE, 4'd0,  13'h1FFF, 13'h0000, 1'b1, WRITE_ACK},
			'{sit_pkg::OP_WRITE, 4'd12, 13'h0001, 13'h0000, 1'b1, WRITE_ACK},
			'{sit_pkg::OP_WRITE, 4'd5,  13'h0020, 13'h1FFF, 1'b1, WRITE_ACK},
			'{sit_pkg::OP_WRITE, 4'd1,  13'h0006, 13'h0000, 1'b1, WRITE_ACK},
			'{sit_pkg::OP_QUERY, 4'd0,  13'h0000, 13'h0F0F, 1'b1, EMPTY_QUERY},
			'{sit_pkg::OP_BUILD, 4'd0,  13'h0000, 13'h0000, 1'b0, BY_MODEL},
			'{sit_pkg::OP_QUERY, 4'd0,  13'h0000, 13'h0000, 1'b0, BY_MODEL},
			'{sit_pkg::OP_QUERY, 4'd0,  13'h0000, 13'h1FFF, 1'b0, BY_MODEL},
			'{sit_pkg::OP_QUERY, 4'd9,  13'h1FFF, 13'h1001, 1'b0, BY_MODEL},
			'{sit_pkg::OP_QUERY, 4'd0,  13'h0000, 13'h0AAA, 1'b0, BY_MODEL},
			'{sit_pkg::OP_QUERY, 4'd0,  13'h0000, 13'h1555, 1'b0, BY_MODEL},
			'{sit_pkg::OP_NONE,  4'd15, 13'h1FFF, 13'h1FFF, 1'b1, BY_MODEL},
			'{sit_pkg::OP_WRITE, 4'd3,  13'h0000, 13'h0000, 1'b1, WRITE_ACK},
			'{sit_pkg::OP_QUERY, 4'd0,  13'h0000, 13'h1FFF, 1'b1, EMPTY_QUERY},
			'{sit_pkg::OP_BUILD, 4'd15, 13'h1FFF, 13'h1FFF, 1'b0, BY_MODEL},
			'{sit_pkg::OP_QUERY, 4'd0,  13'h0000, 13'h0021, 1'b0, BY_MODEL}
		};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_rows[k]) begin
			put_item(directed_rows[k]);
		end
		in_valid <= 1'b0;
		for (int p = 0; p < PHASES; p++) begin
			run_phase(p);
		end
		wait_drained();
		repeat (20) @(posedge clk);
		if (err_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/sit_pkg.sv
hdl/sit_ram.sv
hdl/subset_independence_table.sv
tb/sv/subset_independence_table_tb.sv
